@@ rtl/core/rzb_pkg.sv @@
`default_nettype none
package rzb_pkg;

   localparam int DEF_MAX_WIDTH     = 64;
   localparam int DEF_MAX_HEIGHT    = 64;
   localparam int DEF_DEPTH_ENTRIES = 4096;

   // fixed field widths
   localparam int CRD_W  = 16;
   localparam int Z_W    = 24;
   localparam int DIF_W  = 18;
   localparam int EDGE_W = 36;
   localparam int PROD_W = 44;
   localparam int NUM_W  = 62;
   localparam int POS_W  = 6;
   localparam int DIM_W  = 7;

   localparam int REQ_DATA_W = 168;
   localparam int RSP_DATA_W = 72;

   // command kinds
   localparam logic [1:0] CMD_CLEAR = 2'd0;
   localparam logic [1:0] CMD_EMPTY = 2'd1;
   localparam logic [1:0] CMD_DRAW  = 2'd2;

   // register indexes
   localparam logic [1:0] REG_SCREEN_WIDTH  = 2'd0;
   localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd1;
   localparam logic [1:0] REG_CLEAR_DEPTH   = 2'd2;

   typedef struct packed {
      logic [1:0]               kind;
      logic signed [CRD_W-1:0]  ax;
      logic signed [CRD_W-1:0]  ay;
      logic signed [Z_W-1:0]    az;
      logic signed [CRD_W-1:0]  bx;
      logic signed [CRD_W-1:0]  by;
      logic signed [Z_W-1:0]    bz;
      logic signed [CRD_W-1:0]  cx;
      logic signed [CRD_W-1:0]  cy;
      logic signed [Z_W-1:0]    cz;
      logic signed [DIF_W-1:0]  e0x;
      logic signed [DIF_W-1:0]  e0y;
      logic signed [DIF_W-1:0]  e1x;
      logic signed [DIF_W-1:0]  e1y;
      logic signed [DIF_W-1:0]  e2x;
      logic signed [DIF_W-1:0]  e2y;
      logic signed [EDGE_W-1:0] area;
      logic [POS_W-1:0]         minx;
      logic [POS_W-1:0]         maxx;
      logic [POS_W-1:0]         miny;
      logic [POS_W-1:0]         maxy;
      logic [DIM_W-1:0]         sw;
   } cmd_type;

   typedef struct packed {
      logic valid;
      logic ready;
   } hs_type;

endpackage
`default_nettype wire

@@ rtl/core/triangle_rasterizer_zbuffer.sv @@
// Triangle rasterizer with a depth store.
// req channel: one transaction per operation. tuser 0 clears the depth store to
// clear_depth, tuser 1 draws the triangle carried in tdata.
// rsp channel: one transaction per row of the clipped bounding box, top to
// bottom, tlast on the bottom row. A clear, a degenerate or back-facing
// triangle, or one wholly off screen returns a single row 0, mask 0, tlast 1.
// The front accepts a new transaction only once its last command is pushed
// into a two-entry command queue; the back works one command at a time.
// The back clears the store with one store write per cycle. A draw tests each
// box pixel against the triangle edges and interpolates the depth of each pixel
// inside (shared multiplier for the edge and depth partial products, then
// a restoring divide with a 24-bit quotient). Reset clears control state only;
// the depth store is undefined until the first clear. When rsp_tready is low
// the finished row holds in the output register and the back stalls, while
// the front keeps filling the queue. Configuration registers must be written
// over the csr port only while idle; the block itself does not enforce this.
`default_nettype none
module triangle_rasterizer_zbuffer #(
   parameter int MAX_WIDTH     = rzb_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT    = rzb_pkg::DEF_MAX_HEIGHT,
   parameter int DEPTH_ENTRIES = rzb_pkg::DEF_DEPTH_ENTRIES
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // ax, ay, az, bx, by, bz, cx, cy, cz
   input  wire logic [rzb_pkg::REQ_DATA_W-1:0]    req_tdata,
   // operation
   input  wire logic                              req_tuser,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // row, draw_mask, zero pad
   output logic [rzb_pkg::RSP_DATA_W-1:0]         rsp_tdata,
   output logic                                   rsp_tlast,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [3:0]                        csr_paddr,
   input  wire logic [31:0]                       csr_pwdata,
   output logic [31:0]                            csr_prdata,
   output logic                                   csr_pready
);

   logic [rzb_pkg::DIM_W-1:0] sw_ff, sh_ff, sw_eff, sh_eff;
   logic [rzb_pkg::Z_W-1:0]   cd_ff;
   logic                      csr_wr;
   rzb_pkg::hs_type           push_hs;
   logic                      push_ready;
   rzb_pkg::cmd_type          push_cmd, pop_cmd;
   logic                      pop_valid, pop_ready;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      case (csr_paddr[3:2])
         rzb_pkg::REG_SCREEN_WIDTH:  csr_prdata = {25'b0, sw_ff};
         rzb_pkg::REG_SCREEN_HEIGHT: csr_prdata = {25'b0, sh_ff};
         rzb_pkg::REG_CLEAR_DEPTH:   csr_prdata = {8'b0, cd_ff};
         default:                    csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sw_ff <= 7'd64;
         sh_ff <= 7'd64;
         cd_ff <= 24'h800000;
      end else if (csr_wr) begin
         case (csr_paddr[3:2])
            rzb_pkg::REG_SCREEN_WIDTH:  sw_ff <= csr_pwdata[6:0];
            rzb_pkg::REG_SCREEN_HEIGHT: sh_ff <= csr_pwdata[6:0];
            rzb_pkg::REG_CLEAR_DEPTH:   cd_ff <= csr_pwdata[23:0];
            default: sw_ff <= sw_ff;
         endcase
      end
   end

   // zero acts as one, oversize acts as the maximum
   always_comb begin
      if (sw_ff == '0) begin
         sw_eff = 7'd1;
      end else if (sw_ff > 7'(MAX_WIDTH)) begin
         sw_eff = 7'(MAX_WIDTH);
      end else begin
         sw_eff = sw_ff;
      end
      if (sh_ff == '0) begin
         sh_eff = 7'd1;
      end else if (sh_ff > 7'(MAX_HEIGHT)) begin
         sh_eff = 7'(MAX_HEIGHT);
      end else begin
         sh_eff = sh_ff;
      end
   end

   rzb_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .scr_w       (6'(sw_eff - 7'd1)),
      .scr_h       (6'(sh_eff - 7'd1)),
      .scr_sw      (sw_eff),
      .push_hs_out (push_hs),
      .push_ready  (push_ready),
      .push_cmd    (push_cmd)
   );

   rzb_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_hs    (push_hs),
      .push_cmd   (push_cmd),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd)
   );

   rzb_back #(
      .DEPTH_ENTRIES (DEPTH_ENTRIES)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (pop_valid),
      .q_ready     (pop_ready),
      .q_cmd       (pop_cmd),
      .clear_depth (cd_ff),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast)
   );

endmodule
`default_nettype wire

@@ rtl/core/rzb_front.sv @@
`default_nettype none
module rzb_front (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [rzb_pkg::REQ_DATA_W-1:0]      req_tdata,
   input  wire logic                                req_tuser,
   input  wire logic [rzb_pkg::POS_W-1:0]           scr_w,
   input  wire logic [rzb_pkg::POS_W-1:0]           scr_h,
   input  wire logic [rzb_pkg::DIM_W-1:0]           scr_sw,
   output rzb_pkg::hs_type                          push_hs_out,
   input  wire logic                                push_ready,
   output rzb_pkg::cmd_type                         push_cmd
);

   localparam logic [1:0] F_IDLE = 2'd0;
   localparam logic [1:0] F_MUL  = 2'd1;
   localparam logic [1:0] F_PUSH = 2'd2;

   logic [1:0]                          state_ff, state_in;
   rzb_pkg::cmd_type                    cmd_ff, cmd_in;
   logic                                op_ff, op_in;
   logic                                off_ff, off_in;
   logic signed [rzb_pkg::EDGE_W-1:0]   p1_ff, p1_in, p2_ff, p2_in;

   logic signed [rzb_pkg::CRD_W-1:0]    mnx, mxx, mny, mxy, fmnx, fmxx, fmny, fmxy;
   logic signed [rzb_pkg::DIF_W-1:0]    d_cax, d_cay;
   logic signed [rzb_pkg::EDGE_W-1:0]   area;

   function automatic logic signed [rzb_pkg::DIF_W-1:0] sub18(
      input logic signed [rzb_pkg::CRD_W-1:0] a,
      input logic signed [rzb_pkg::CRD_W-1:0] b);
      sub18 = {{2{a[rzb_pkg::CRD_W-1]}}, a} - {{2{b[rzb_pkg::CRD_W-1]}}, b};
   endfunction

   function automatic logic signed [rzb_pkg::CRD_W-1:0] min3(
      input logic signed [rzb_pkg::CRD_W-1:0] a,
      input logic signed [rzb_pkg::CRD_W-1:0] b,
      input logic signed [rzb_pkg::CRD_W-1:0] c);
      logic signed [rzb_pkg::CRD_W-1:0] m;
      m    = (a < b) ? a : b;
      min3 = (m < c) ? m : c;
   endfunction

   function automatic logic signed [rzb_pkg::CRD_W-1:0] max3(
      input logic signed [rzb_pkg::CRD_W-1:0] a,
      input logic signed [rzb_pkg::CRD_W-1:0] b,
      input logic signed [rzb_pkg::CRD_W-1:0] c);
      logic signed [rzb_pkg::CRD_W-1:0] m;
      m    = (a > b) ? a : b;
      max3 = (m > c) ? m : c;
   endfunction

   always_comb begin
      mnx  = min3(cmd_ff.ax, cmd_ff.bx, cmd_ff.cx);
      mxx  = max3(cmd_ff.ax, cmd_ff.bx, cmd_ff.cx);
      mny  = min3(cmd_ff.ay, cmd_ff.by, cmd_ff.cy);
      mxy  = max3(cmd_ff.ay, cmd_ff.by, cmd_ff.cy);
      fmnx = mnx >>> 4;
      fmxx = mxx >>> 4;
      fmny = mny >>> 4;
      fmxy = mxy >>> 4;
      d_cax = sub18(cmd_ff.cx, cmd_ff.ax);
      d_cay = sub18(cmd_ff.cy, cmd_ff.ay);
      area  = p1_ff - p2_ff;
   end

   always_comb begin
      state_in = state_ff;
      cmd_in   = cmd_ff;
      op_in    = op_ff;
      off_in   = off_ff;
      p1_in    = p1_ff;
      p2_in    = p2_ff;
      req_tready        = (state_ff == F_IDLE);
      push_hs_out.valid = (state_ff == F_PUSH);
      push_hs_out.ready = push_ready;
      push_cmd          = cmd_ff;

      case (state_ff)
         F_IDLE: begin
            if (req_tvalid) begin
               op_in     = req_tuser;
               cmd_in.ax = req_tdata[15:0];
               cmd_in.ay = req_tdata[31:16];
               cmd_in.az = req_tdata[55:32];
               cmd_in.bx = req_tdata[71:56];
               cmd_in.by = req_tdata[87:72];
               cmd_in.bz = req_tdata[111:88];
               cmd_in.cx = req_tdata[127:112];
               cmd_in.cy = req_tdata[143:128];
               cmd_in.cz = req_tdata[167:144];
               state_in  = F_MUL;
            end
         end
         F_MUL: begin
            cmd_in.e0x = sub18(cmd_ff.cx, cmd_ff.bx);
            cmd_in.e0y = sub18(cmd_ff.cy, cmd_ff.by);
            cmd_in.e1x = sub18(cmd_ff.ax, cmd_ff.cx);
            cmd_in.e1y = sub18(cmd_ff.ay, cmd_ff.cy);
            cmd_in.e2x = sub18(cmd_ff.bx, cmd_ff.ax);
            cmd_in.e2y = sub18(cmd_ff.by, cmd_ff.ay);
            p1_in = d_cax * sub18(cmd_ff.by, cmd_ff.ay);
            p2_in = d_cay * sub18(cmd_ff.bx, cmd_ff.ax);
            off_in = (mnx > $signed({6'b0, scr_w, 4'b0})) || (mxx < 0) ||
                     (mny > $signed({6'b0, scr_h, 4'b0})) || (mxy < 0);
            cmd_in.minx = (fmnx < 0) ? '0 : fmnx[rzb_pkg::POS_W-1:0];
            cmd_in.miny = (fmny < 0) ? '0 : fmny[rzb_pkg::POS_W-1:0];
            cmd_in.maxx = (fmxx > $signed({10'b0, scr_w})) ? scr_w
                                                            : fmxx[rzb_pkg::POS_W-1:0];
            cmd_in.maxy = (fmxy > $signed({10'b0, scr_h})) ? scr_h
                                                            : fmxy[rzb_pkg::POS_W-1:0];
            cmd_in.sw   = scr_sw;
            state_in    = F_PUSH;
         end
         F_PUSH: begin
            cmd_in.area = area;
            if (!op_ff) begin
               cmd_in.kind = rzb_pkg::CMD_CLEAR;
            end else if (off_ff || area <= 0) begin
               cmd_in.kind = rzb_pkg::CMD_EMPTY;
            end else begin
               cmd_in.kind = rzb_pkg::CMD_DRAW;
            end
            push_cmd = cmd_in;
            if (push_ready) begin
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cmd_ff <= cmd_in;
      op_ff  <= op_in;
      off_ff <= off_in;
      p1_ff  <= p1_in;
      p2_ff  <= p2_in;
   end

endmodule
`default_nettype wire

@@ rtl/core/rzb_queue.sv @@
`default_nettype none
module rzb_queue (
   input  wire logic        clock,
   input  wire logic        reset,
   input  rzb_pkg::hs_type  push_hs,
   input  rzb_pkg::cmd_type push_cmd,
   output logic             push_ready,
   output logic             pop_valid,
   input  wire logic        pop_ready,
   output rzb_pkg::cmd_type pop_cmd
);

   rzb_pkg::cmd_type slot_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             do_push, do_pop;

   always_comb begin
      push_ready = (count_ff != 2'd2);
      pop_valid  = (count_ff != 2'd0);
      pop_cmd    = slot_ff[rd_ptr_ff];
      do_push    = push_hs.valid && push_ready;
      do_pop     = pop_valid && pop_ready;
      wr_ptr_in  = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in  = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in   = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule
`default_nettype wire

@@ rtl/core/rzb_back.sv @@
`default_nettype none
module rzb_back #(
   parameter int DEPTH_ENTRIES = rzb_pkg::DEF_DEPTH_ENTRIES
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             q_valid,
   output logic                                  q_ready,
   input  rzb_pkg::cmd_type                      q_cmd,
   input  wire logic [rzb_pkg::Z_W-1:0]          clear_depth,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   output logic [rzb_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   output logic                                  rsp_tlast
);

   localparam int AW    = $clog2(DEPTH_ENTRIES);
   localparam int IDX_W = 13;
   localparam int REM_W = rzb_pkg::NUM_W - 1;
   localparam int Q_W   = rzb_pkg::Z_W;
   localparam logic [AW-1:0]    LAST_ADDR = AW'(DEPTH_ENTRIES - 1);
   localparam logic [IDX_W-1:0] IDX_LIMIT = IDX_W'(DEPTH_ENTRIES);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_CLEAR  = 4'd1;
   localparam logic [3:0] S_ROW    = 4'd2;
   localparam logic [3:0] S_EDGE   = 4'd3;
   localparam logic [3:0] S_TEST   = 4'd4;
   localparam logic [3:0] S_NUM    = 4'd5;
   localparam logic [3:0] S_DIVSET = 4'd6;
   localparam logic [3:0] S_DIV    = 4'd7;
   localparam logic [3:0] S_CMP    = 4'd8;
   localparam logic [3:0] S_NEXT   = 4'd9;
   localparam logic [3:0] S_EMIT   = 4'd10;

   logic [3:0]                          state_ff, state_in;
   rzb_pkg::cmd_type                    cmd_ff, cmd_in;
   logic [rzb_pkg::POS_W-1:0]           x_ff, x_in, y_ff, y_in;
   logic [63:0]                         mask_ff, mask_in;
   logic [IDX_W-1:0]                    base_ff, base_in;
   logic [2:0]                          step_ff, step_in;
   logic signed [rzb_pkg::EDGE_W-1:0]   w0_ff, w0_in, w1_ff, w1_in, w2_ff, w2_in;
   logic signed [rzb_pkg::PROD_W-1:0]   prod_ff, prod_in;
   logic signed [rzb_pkg::NUM_W-1:0]    num_ff, num_in;
   logic [REM_W-1:0]                    rem_ff, rem_in, dsr_ff, dsr_in;
   logic [Q_W-1:0]                      q_ff, q_in;
   logic                                neg_ff, neg_in;
   logic [4:0]                          cnt_ff, cnt_in;
   logic [AW-1:0]                       clr_ff, clr_in;
   logic                                elast_ff, elast_in;
   logic                                ovalid_ff, ovalid_in;
   logic [rzb_pkg::POS_W-1:0]           orow_ff, orow_in;
   logic [63:0]                         omask_ff, omask_in;
   logic                                olast_ff, olast_in;

   logic [rzb_pkg::Z_W-1:0]             mem [DEPTH_ENTRIES];
   logic [rzb_pkg::Z_W-1:0]             rd_ff;
   logic                                mem_we, mem_re;
   logic [AW-1:0]                       mem_wa, mem_ra;
   logic [rzb_pkg::Z_W-1:0]             mem_wd;

   logic signed [24:0]                  mul_a;
   logic signed [18:0]                  mul_b;
   logic signed [rzb_pkg::DIF_W-1:0]    px_s, py_s;
   logic signed [rzb_pkg::EDGE_W-1:0]   pe;
   logic signed [rzb_pkg::NUM_W-1:0]    pn_lo, pn_hi;
   logic [IDX_W-1:0]                    idx;
   logic signed [rzb_pkg::NUM_W-1:0]    num_abs;
   logic signed [Q_W-1:0]               zval;

   function automatic logic signed [24:0] sx18(input logic signed [rzb_pkg::DIF_W-1:0] v);
      sx18 = {{7{v[rzb_pkg::DIF_W-1]}}, v};
   endfunction

   function automatic logic signed [rzb_pkg::DIF_W-1:0] sx16(
      input logic signed [rzb_pkg::CRD_W-1:0] v);
      sx16 = {{2{v[rzb_pkg::CRD_W-1]}}, v};
   endfunction

   // shared multiplier operand select
   always_comb begin
      px_s  = $signed({8'b0, x_ff, 4'b0});
      py_s  = $signed({8'b0, y_ff, 4'b0});
      mul_a = '0;
      mul_b = '0;
      if (state_ff == S_EDGE) begin
         case (step_ff)
            3'd0: begin mul_a = sx18(px_s - sx16(cmd_ff.bx)); mul_b = 19'(cmd_ff.e0y); end
            3'd1: begin mul_a = sx18(py_s - sx16(cmd_ff.by)); mul_b = 19'(cmd_ff.e0x); end
            3'd2: begin mul_a = sx18(px_s - sx16(cmd_ff.cx)); mul_b = 19'(cmd_ff.e1y); end
            3'd3: begin mul_a = sx18(py_s - sx16(cmd_ff.cy)); mul_b = 19'(cmd_ff.e1x); end
            3'd4: begin mul_a = sx18(px_s - sx16(cmd_ff.ax)); mul_b = 19'(cmd_ff.e2y); end
            3'd5: begin mul_a = sx18(py_s - sx16(cmd_ff.ay)); mul_b = 19'(cmd_ff.e2x); end
            default: begin mul_a = '0; mul_b = '0; end
         endcase
      end else begin
         case (step_ff)
            3'd0: begin mul_a = 25'(cmd_ff.az); mul_b = {1'b0, w0_ff[17:0]}; end
            3'd1: begin mul_a = 25'(cmd_ff.az); mul_b = {1'b0, w0_ff[35:18]}; end
            3'd2: begin mul_a = 25'(cmd_ff.bz); mul_b = {1'b0, w1_ff[17:0]}; end
            3'd3: begin mul_a = 25'(cmd_ff.bz); mul_b = {1'b0, w1_ff[35:18]}; end
            3'd4: begin mul_a = 25'(cmd_ff.cz); mul_b = {1'b0, w2_ff[17:0]}; end
            3'd5: begin mul_a = 25'(cmd_ff.cz); mul_b = {1'b0, w2_ff[35:18]}; end
            default: begin mul_a = '0; mul_b = '0; end
         endcase
      end
      prod_in = mul_a * mul_b;
      pe      = prod_ff[rzb_pkg::EDGE_W-1:0];
      pn_lo   = {{18{prod_ff[rzb_pkg::PROD_W-1]}}, prod_ff};
      pn_hi   = {prod_ff, 18'b0};
      idx     = base_ff + IDX_W'(x_ff);
      num_abs = num_ff[rzb_pkg::NUM_W-1] ? -num_ff : num_ff;
      zval    = neg_ff ? -$signed(q_ff) : $signed(q_ff);
   end

   always_comb begin
      state_in  = state_ff;
      cmd_in    = cmd_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      mask_in   = mask_ff;
      base_in   = base_ff;
      step_in   = step_ff;
      w0_in     = w0_ff;
      w1_in     = w1_ff;
      w2_in     = w2_ff;
      num_in    = num_ff;
      rem_in    = rem_ff;
      dsr_in    = dsr_ff;
      q_in      = q_ff;
      neg_in    = neg_ff;
      cnt_in    = cnt_ff;
      clr_in    = clr_ff;
      elast_in  = elast_ff;
      ovalid_in = ovalid_ff;
      orow_in   = orow_ff;
      omask_in  = omask_ff;
      olast_in  = olast_ff;
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      mem_wa    = clr_ff;
      mem_ra    = idx[AW-1:0];
      mem_wd    = clear_depth;
      q_ready   = (state_ff == S_IDLE);

      if (ovalid_ff && rsp_tready) begin
         ovalid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               cmd_in   = q_cmd;
               mask_in  = '0;
               y_in     = '0;
               elast_in = 1'b1;
               clr_in   = '0;
               case (q_cmd.kind)
                  rzb_pkg::CMD_CLEAR: state_in = S_CLEAR;
                  rzb_pkg::CMD_DRAW: begin
                     y_in     = q_cmd.miny;
                     state_in = S_ROW;
                  end
                  default: state_in = S_EMIT;
               endcase
            end
         end
         S_CLEAR: begin
            mem_we = 1'b1;
            if (clr_ff == LAST_ADDR) begin
               state_in = S_EMIT;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end
         S_ROW: begin
            base_in  = IDX_W'(y_ff) * IDX_W'(cmd_ff.sw);
            x_in     = cmd_ff.minx;
            mask_in  = '0;
            w0_in    = '0;
            w1_in    = '0;
            w2_in    = '0;
            step_in  = '0;
            state_in = S_EDGE;
         end
         S_EDGE: begin
            case (step_ff)
               3'd1: w0_in = w0_ff + pe;
               3'd2: w0_in = w0_ff - pe;
               3'd3: w1_in = w1_ff + pe;
               3'd4: w1_in = w1_ff - pe;
               3'd5: w2_in = w2_ff + pe;
               3'd6: w2_in = w2_ff - pe;
               default: w0_in = w0_ff;
            endcase
            if (step_ff == 3'd6) begin
               state_in = S_TEST;
            end else begin
               step_in = step_ff + 3'd1;
            end
         end
         S_TEST: begin
            // drop pixels outside any edge or past the store
            if (w0_ff < 0 || w1_ff < 0 || w2_ff < 0 || idx >= IDX_LIMIT) begin
               state_in = S_NEXT;
            end else begin
               mem_re   = 1'b1;
               num_in   = '0;
               step_in  = '0;
               state_in = S_NUM;
            end
         end
         S_NUM: begin
            case (step_ff)
               3'd1, 3'd3, 3'd5: num_in = num_ff + pn_lo;
               3'd2, 3'd4, 3'd6: num_in = num_ff + pn_hi;
               default: num_in = num_ff;
            endcase
            if (step_ff == 3'd6) begin
               state_in = S_DIVSET;
            end else begin
               step_in = step_ff + 3'd1;
            end
         end
         S_DIVSET: begin
            neg_in   = num_ff[rzb_pkg::NUM_W-1];
            rem_in   = num_abs[REM_W-1:0];
            dsr_in   = {2'b0, cmd_ff.area, 23'b0};
            q_in     = '0;
            cnt_in   = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            if (rem_ff >= dsr_ff) begin
               rem_in = rem_ff - dsr_ff;
               q_in   = {q_ff[Q_W-2:0], 1'b1};
            end else begin
               q_in   = {q_ff[Q_W-2:0], 1'b0};
            end
            dsr_in = dsr_ff >> 1;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'(Q_W - 1)) begin
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            if (zval >= $signed(rd_ff)) begin
               mem_we  = 1'b1;
               mem_wa  = idx[AW-1:0];
               mem_wd  = zval;
               mask_in = mask_ff | (64'd1 << x_ff);
            end
            state_in = S_NEXT;
         end
         S_NEXT: begin
            if (x_ff == cmd_ff.maxx) begin
               elast_in = (y_ff == cmd_ff.maxy);
               state_in = S_EMIT;
            end else begin
               x_in     = x_ff + 1'b1;
               w0_in    = '0;
               w1_in    = '0;
               w2_in    = '0;
               step_in  = '0;
               state_in = S_EDGE;
            end
         end
         S_EMIT: begin
            if (!ovalid_ff || rsp_tready) begin
               ovalid_in = 1'b1;
               orow_in   = y_ff;
               omask_in  = mask_ff;
               olast_in  = elast_ff;
               if (cmd_ff.kind != rzb_pkg::CMD_DRAW || elast_ff) begin
                  state_in = S_IDLE;
               end else begin
                  y_in     = y_ff + 1'b1;
                  state_in = S_ROW;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         rd_ff <= mem[mem_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         ovalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         ovalid_ff <= ovalid_in;
      end
      cmd_ff   <= cmd_in;
      x_ff     <= x_in;
      y_ff     <= y_in;
      mask_ff  <= mask_in;
      base_ff  <= base_in;
      step_ff  <= step_in;
      w0_ff    <= w0_in;
      w1_ff    <= w1_in;
      w2_ff    <= w2_in;
      prod_ff  <= prod_in;
      num_ff   <= num_in;
      rem_ff   <= rem_in;
      dsr_ff   <= dsr_in;
      q_ff     <= q_in;
      neg_ff   <= neg_in;
      cnt_ff   <= cnt_in;
      clr_ff   <= clr_in;
      elast_ff <= elast_in;
      orow_ff  <= orow_in;
      omask_ff <= omask_in;
      olast_ff <= olast_in;
   end

   assign rsp_tvalid = ovalid_ff;
   assign rsp_tdata  = {2'b0, omask_ff, orow_ff};
   assign rsp_tlast  = olast_ff;

endmodule
`default_nettype wire

@@ rtl/core/rzb_checker.sv @@
`default_nettype none
module rzb_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           rsp_tvalid,
   input wire logic                           rsp_tready,
   input wire logic [rzb_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input wire logic                           rsp_tlast,
   input wire logic                           csr_pready
);

   // reset empties the output register
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp transaction dropped while stalled");

   a_hold_data: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp payload changed while stalled");

   // pad bits above draw_mask stay zero and csr_pready stays high
   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[71:70] == 2'b00 && csr_pready)
      else $error("rsp pad bits set or csr not ready");

endmodule

bind triangle_rasterizer_zbuffer rzb_checker u_rzb_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .csr_pready (csr_pready)
);
`default_nettype wire

@@ bench/tb_triangle_rasterizer_zbuffer.sv @@
`timescale 1ns / 100ps
`default_nettype none
module tb_triangle_rasterizer_zbuffer;

   localparam bit OP_CLEAR = 1'b0;
   localparam bit OP_DRAW  = 1'b1;
   localparam int STORE_ENTRIES = 4096;
   localparam int SCREEN_MAX    = 64;
   localparam int REQ_W = rzb_pkg::REQ_DATA_W;
   localparam int RSP_W = rzb_pkg::RSP_DATA_W;
   localparam longint CYCLE_LIMIT = 40000000;

   typedef struct {
      bit [5:0]  row;
      bit [63:0] mask;
      bit        last;
   } mask_row_type;

   class raster_scoreboard;
      int           depth_mem[STORE_ENTRIES];
      bit [6:0]     width_reg = 7'd64;
      bit [6:0]     height_reg = 7'd64;
      int           clear_z = -8388608;
      mask_row_type expected_rows[$];
      int           mismatches = 0;

      function longint edge_fn(longint x0, longint y0, longint x1, longint y1,
                               longint px, longint py);
         return (px - x0) * (y1 - y0) - (py - y0) * (x1 - x0);
      endfunction

      function longint min3(longint a, longint b, longint c);
         longint m;
         m = a < b ? a : b;
         return m < c ? m : c;
      endfunction

      function longint max3(longint a, longint b, longint c);
         longint m;
         m = a > b ? a : b;
         return m > c ? m : c;
      endfunction

      function void push_row(int y, bit [63:0] m, bit l);
         mask_row_type r;
         r.row = y[5:0];
         r.mask = m;
         r.last = l;
         expected_rows.push_back(r);
      endfunction

      function void note_request(bit op, logic [REQ_W-1:0] d);
         longint ax, ay, az, bx, by, bz, cx, cy, cz, area, w0, w1, w2, z;
         int sw, sh, minx, maxx, miny, maxy, idx;
         bit [63:0] m;
         if (op == OP_CLEAR) begin
            foreach (depth_mem[i]) depth_mem[i] = clear_z;
            push_row(0, 64'd0, 1'b1);
            return;
         end
         ax = longint'($signed(d[15:0]));    ay = longint'($signed(d[31:16]));
         az = longint'($signed(d[55:32]));   bx = longint'($signed(d[71:56]));
         by = longint'($signed(d[87:72]));   bz = longint'($signed(d[111:88]));
         cx = longint'($signed(d[127:112])); cy = longint'($signed(d[143:128]));
         cz = longint'($signed(d[167:144]));
         sw = width_reg == 0 ? 1 : (width_reg > SCREEN_MAX ? SCREEN_MAX : width_reg);
         sh = height_reg == 0 ? 1 : (height_reg > SCREEN_MAX ? SCREEN_MAX : height_reg);
         area = edge_fn(ax, ay, bx, by, cx, cy);
         if (min3(ax, bx, cx) > longint'(sw - 1) * 16 || max3(ax, bx, cx) < 0 ||
             min3(ay, by, cy) > longint'(sh - 1) * 16 || max3(ay, by, cy) < 0 ||
             area <= 0) begin
            push_row(0, 64'd0, 1'b1);
            return;
         end
         // arithmetic shift floors the Q12.4 coordinate
         minx = int'(min3(ax, bx, cx) >>> 4); if (minx < 0) minx = 0;
         maxx = int'(max3(ax, bx, cx) >>> 4); if (maxx > sw - 1) maxx = sw - 1;
         miny = int'(min3(ay, by, cy) >>> 4); if (miny < 0) miny = 0;
         maxy = int'(max3(ay, by, cy) >>> 4); if (maxy > sh - 1) maxy = sh - 1;
         for (int y = miny; y <= maxy; y++) begin
            m = '0;
            for (int x = minx; x <= maxx; x++) begin
               w0 = edge_fn(bx, by, cx, cy, x * 16, y * 16);
               w1 = edge_fn(cx, cy, ax, ay, x * 16, y * 16);
               w2 = edge_fn(ax, ay, bx, by, x * 16, y * 16);
               if (w0 < 0 || w1 < 0 || w2 < 0) continue;
               idx = y * sw + x;
               if (idx >= STORE_ENTRIES) continue;
               z = (az * w0 + bz * w1 + cz * w2) / area;
               if (z < longint'(depth_mem[idx])) continue;
               depth_mem[idx] = int'(z);
               m[x] = 1'b1;
            end
            push_row(y, m, y == maxy);
         end
      endfunction

      function void check_result(logic [RSP_W-1:0] d, logic l);
         mask_row_type e;
         if (expected_rows.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected row transaction: row %0d mask %h last %b",
                        d[5:0], d[69:6], l);
            return;
         end
         e = expected_rows.pop_front();
         if (d[5:0] !== e.row || d[69:6] !== e.mask || l !== e.last) begin
            mismatches++;
            if (mismatches <= 10)
               $display("row mismatch: expected row %0d mask %h last %b, got row %0d mask %h last %b",
                        e.row, e.mask, e.last, d[5:0], d[69:6], l);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic req_tuser = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;
   logic rsp_tlast;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [3:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   raster_scoreboard sb = new();
   longint cycle_count = 0;
   int hold_request = 0;
   int hold_left = 0;
   int stall_left = 0;

   triangle_rasterizer_zbuffer u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata), .csr_pready(csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // result side: check every accepted row, then pick the next ready level
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata, rsp_tlast);
      if (hold_request > 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if ($urandom_range(0, 99) < 30)
            stall_left = ($urandom_range(0, 99) < 8) ? $urandom_range(20, 80)
                                                     : $urandom_range(1, 3);
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   task automatic send_item(bit op, logic [REQ_W-1:0] d);
      int gap;
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= d;
      do @(posedge clock); while (!req_tready);
      sb.note_request(op, d);
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_tri(int ax, int ay, int az, int bx, int by, int bz,
                           int cx, int cy, int cz);
      send_item(OP_DRAW, {cz[23:0], cy[15:0], cx[15:0], bz[23:0], by[15:0], bx[15:0],
                          az[23:0], ay[15:0], ax[15:0]});
   endtask

   task automatic csr_write(logic [1:0] index, logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {index, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (index)
         rzb_pkg::REG_SCREEN_WIDTH:  sb.width_reg = value[6:0];
         rzb_pkg::REG_SCREEN_HEIGHT: sb.height_reg = value[6:0];
         default:                    sb.clear_z = int'($signed(value[23:0]));
      endcase
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.expected_rows.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic set_screen(int w, int h, int cz);
      csr_write(rzb_pkg::REG_SCREEN_WIDTH, w);
      csr_write(rzb_pkg::REG_SCREEN_HEIGHT, h);
      csr_write(rzb_pkg::REG_CLEAR_DEPTH, cz);
      send_item(OP_CLEAR, REQ_W'({$urandom(), $urandom(), $urandom(), $urandom(),
                                  $urandom(), $urandom()}));
   endtask

   // small triangle near a random spot; mostly wound clockwise
   task automatic rand_tri(int sw, int sh, int spread, bit wide_z);
      int ox, oy, v[6], z[3], t;
      longint area;
      ox = $urandom_range(0, sw * 16 + 16) - 8;
      oy = $urandom_range(0, sh * 16 + 16) - 8;
      foreach (v[i]) v[i] = (i % 2 ? oy : ox) + $urandom_range(0, 2 * spread) - spread;
      foreach (z[i])
         z[i] = wide_z ? int'($signed($urandom_range(0, 24'hFFFFFF) << 8)) >>> 8
                       : $urandom_range(0, 4000) - 2000;
      area = longint'(v[4] - v[0]) * (v[3] - v[1]) - longint'(v[5] - v[1]) * (v[2] - v[0]);
      if (area < 0 && $urandom_range(0, 99) < 85) begin
         t = v[2]; v[2] = v[4]; v[4] = t;
         t = v[3]; v[3] = v[5]; v[5] = t;
      end
      send_tri(v[0], v[1], z[0], v[2], v[3], z[1], v[4], v[5], z[2]);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // full screen, lowest clear depth
      set_screen(64, 64, -8388608);
      send_tri(0, 0, 100, 0, 160, 200, 160, 0, 300);
      send_tri(0, 0, 50, 160, 0, 60, 0, 160, 70);        // counterclockwise
      send_tri(0, 0, 10, 32, 32, 10, 64, 64, 10);        // zero area
      send_tri(-400, -400, 5, -400, -100, 5, -100, -400, 5);  // above and left
      send_tri(1100, 10, 5, 1100, 90, 5, 1500, 10, 5);   // right of screen
      send_tri(0, 0, 0, 0, 2000, 0, 2000, 0, 0);         // covers most of the screen
      send_tri(8, 8, 50, 8, 120, 50, 120, 8, 50);        // in front of the last one
      send_tri(8, 8, 0, 8, 120, 0, 120, 8, 0);           // behind the last one, so not drawn
      send_tri(900, 900, 8388607, 900, 1010, -8388608, 1010, 900, 8388607);
      send_tri(-5, -5, -8388608, -5, 40, 8388607, 40, -5, -8388608);
      for (int i = 0; i < 35; i++) rand_tri(64, 64, $urandom_range(0, 9) ? 64 : 200, i % 4 == 0);
      drain();

      // small screen with raw noise over every bit
      set_screen(8, 8, 0);
      send_tri(-32768, -32768, 8388607, -32768, 32767, 8388607, 32767, -32768, 8388607);
      for (int i = 0; i < 40; i++) begin
         if (i % 3 == 0)
            send_item($urandom_range(0, 9) == 0 ? OP_CLEAR : OP_DRAW,
                      REQ_W'({$urandom(), $urandom(), $urandom(), $urandom(),
                              $urandom(), $urandom()}));
         else
            rand_tri(8, 8, 48, 1'b1);
      end
      drain();

      // zero size acts as one pixel, highest clear depth
      set_screen(0, 0, 8388607);
      send_tri(0, 0, 8388607, 0, 16, 8388607, 16, 0, 8388607);
      for (int i = 0; i < 10; i++) rand_tri(1, 1, 24, 1'b1);
      drain();

      // oversize clamps to the maximum; receiver holds off while input backs up
      set_screen(127, 127, -5);
      hold_request = 3000;
      for (int i = 0; i < 30; i++) rand_tri(64, 64, 48, 1'b0);
      drain();

      set_screen(37, 13, -1000);
      for (int i = 0; i < 25; i++) rand_tri(37, 13, 64, 1'b0);
      drain();

      if (sb.mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end
endmodule
`default_nettype wire

@@ files.f @@
rtl/core/rzb_pkg.sv
rtl/core/rzb_front.sv
rtl/core/rzb_queue.sv
rtl/core/rzb_back.sv
rtl/core/triangle_rasterizer_zbuffer.sv
rtl/core/rzb_checker.sv
bench/tb_triangle_rasterizer_zbuffer.sv
